>>> hw/rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

    // Frame header constants
    localparam logic [7:0] FIRST_BYTE     = 8'h82;
    localparam logic [6:0] LEN_ESC16      = 7'd126;
    localparam logic [6:0] LEN_ESC64      = 7'd127;
    localparam logic [2:0] LEN16_LAST_IDX = 3'd1;
    localparam logic [2:0] LEN64_LAST_IDX = 3'd7;
    localparam logic [1:0] KEY_LAST_IDX   = 2'd3;
    localparam logic [31:0] LIMIT_RESET   = 32'd65536;
    localparam logic [32:0] KEY_BYTES     = 33'd4;

    // Parser phase
    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_LEN16,
        PH_LEN64,
        PH_KEY,
        PH_DATA,
        PH_FAILED
    } phase_t;

    // Result kind
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Error codes
    typedef enum logic [1:0] {
        ERR_FIRST_BYTE = 2'd0,
        ERR_MASK_CLEAR = 2'd1,
        ERR_TOO_LONG   = 2'd2
    } err_t;

    // One result from the parser core
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        logic       last;
        err_t       code;
    } result_t;

endpackage

>>> hw/rtl/websocket_frame_deframer.sv
// Top level: stream ports, limit register and result register.
// Results reach the m_ side through the output register, loaded on the input byte transfer.
// Throughput: one byte per cycle; the single output register stalls input only when
// it holds a result and m_tready is low.
// Reset (aresetn low, synchronous): parser back to awaiting first byte, error state
// cleared, frame_limit back to 65536, output register emptied.
`timescale 1ns / 1ps

module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: frame_limit write
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] fault_code, [15:10] zero
    output logic        m_tlast,   // last_of_frame
    output logic [1:0]  m_tuser    // [1:0] kind
);
    import wsd_pkg::*;

    logic [31:0] limit_reg;
    logic        accept;
    result_t     result;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg;
    err_t        m_code_reg;
    logic        m_last_reg;
    kind_t       m_kind_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Frame limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    wsd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .rx_byte     (s_tdata),
        .frame_limit (limit_reg),
        .result      (result)
    );

    // Output valid: load on input transfer, drop once the result is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = result.valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result.data;
            m_code_reg <= result.code;
            m_last_reg <= result.last;
            m_kind_reg <= result.kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_code_reg, m_data_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_kind_reg;

endmodule

>>> hw/rtl/wsd_core.sv
// Frame header parser, length check and payload unmasking.
`timescale 1ns / 1ps

module wsd_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic [31:0]       frame_limit,
    output wsd_pkg::result_t  result
);
    import wsd_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [31:0] len_lo_reg,  len_lo_next;
    logic        len_hi_reg,  len_hi_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] key_reg,     key_next;
    logic [1:0]  pos_reg,     pos_next;
    logic [31:0] remain_reg,  remain_next;

    // Length candidate for the check (low word plus sticky upper-word flag)
    logic [31:0] chk_lo;
    logic        chk_hi;
    logic        too_long;
    logic [7:0]  key_byte;

    // Length check: length + 4 > limit, upper word nonzero is always too long
    assign too_long = chk_hi || (({1'b0, chk_lo} + KEY_BYTES) > {1'b0, frame_limit});

    // Key byte at current payload position, first key byte in the top bits
    always_comb begin
        case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next state and result
    always_comb begin
        phase_next   = phase_reg;
        len_lo_next  = len_lo_reg;
        len_hi_next  = len_hi_reg;
        hdr_cnt_next = hdr_cnt_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        remain_next  = remain_reg;
        chk_lo       = {len_lo_reg[23:0], rx_byte};
        chk_hi       = len_hi_reg || (len_lo_reg[31:24] != 8'd0);
        result       = '{valid: 1'b0, kind: KIND_DATA, data: 8'd0, last: 1'b0,
                         code: ERR_FIRST_BYTE};

        if (accept) begin
            case (phase_reg)
                PH_FIRST: begin
                    if (rx_byte != FIRST_BYTE) begin
                        phase_next   = PH_FAILED;
                        result.valid = 1'b1;
                        result.kind  = KIND_ERROR;
                        result.code  = ERR_FIRST_BYTE;
                    end else begin
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    chk_lo       = {25'd0, rx_byte[6:0]};
                    chk_hi       = 1'b0;
                    len_lo_next  = 32'd0;
                    len_hi_next  = 1'b0;
                    hdr_cnt_next = 3'd0;
                    if (!rx_byte[7]) begin
                        phase_next   = PH_FAILED;
                        result.valid = 1'b1;
                        result.kind  = KIND_ERROR;
                        result.code  = ERR_MASK_CLEAR;
                    end else if (rx_byte[6:0] == LEN_ESC64) begin
                        phase_next = PH_LEN64;
                    end else if (rx_byte[6:0] == LEN_ESC16) begin
                        phase_next = PH_LEN16;
                    end else if (too_long) begin
                        phase_next   = PH_FAILED;
                        result.valid = 1'b1;
                        result.kind  = KIND_ERROR;
                        result.code  = ERR_TOO_LONG;
                    end else begin
                        remain_next = chk_lo;
                        key_next    = 32'd0;
                        phase_next  = PH_KEY;
                    end
                end
                PH_LEN16, PH_LEN64: begin
                    len_lo_next  = chk_lo;
                    len_hi_next  = chk_hi;
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if ((phase_reg == PH_LEN16 && hdr_cnt_reg == LEN16_LAST_IDX) ||
                        (phase_reg == PH_LEN64 && hdr_cnt_reg == LEN64_LAST_IDX)) begin
                        hdr_cnt_next = 3'd0;
                        if (too_long) begin
                            phase_next   = PH_FAILED;
                            result.valid = 1'b1;
                            result.kind  = KIND_ERROR;
                            result.code  = ERR_TOO_LONG;
                        end else begin
                            remain_next = chk_lo;
                            key_next    = 32'd0;
                            phase_next  = PH_KEY;
                        end
                    end
                end
                PH_KEY: begin
                    key_next     = {key_reg[23:0], rx_byte};
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if (hdr_cnt_reg[1:0] == KEY_LAST_IDX) begin
                        hdr_cnt_next = 3'd0;
                        pos_next     = 2'd0;
                        if (remain_reg == 32'd0) begin
                            phase_next   = PH_FIRST;
                            result.valid = 1'b1;
                            result.kind  = KIND_EMPTY;
                            result.last  = 1'b1;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    pos_next     = pos_reg + 2'd1;
                    remain_next  = remain_reg - 32'd1;
                    result.valid = 1'b1;
                    result.kind  = KIND_DATA;
                    result.data  = rx_byte ^ key_byte;
                    result.last  = (remain_reg == 32'd1);
                    if (remain_reg == 32'd1) begin
                        phase_next = PH_FIRST;
                    end
                end
                PH_FAILED: begin
                    phase_next = PH_FAILED;
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIRST;
            len_lo_reg  <= 32'd0;
            len_hi_reg  <= 1'b0;
            hdr_cnt_reg <= 3'd0;
            key_reg     <= 32'd0;
            pos_reg     <= 2'd0;
            remain_reg  <= 32'd0;
        end else begin
            phase_reg   <= phase_next;
            len_lo_reg  <= len_lo_next;
            len_hi_reg  <= len_hi_next;
            hdr_cnt_reg <= hdr_cnt_next;
            key_reg     <= key_next;
            pos_reg     <= pos_next;
            remain_reg  <= remain_next;
        end
    end

endmodule
